// ----- rtl/tsq_pkg.sv -----
// ----------------------------------------------------------------------------
// tsq_pkg
// Types, codes and defaults for the two-stack queue.
// ----------------------------------------------------------------------------
package tsq_pkg;

   localparam int STACK_DEPTH_DEFAULT = 128;
   localparam int DATA_WIDTH_DEFAULT  = 32;
   localparam int VALUE_WIDTH         = 32;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      op_type                         operation;
      logic signed [VALUE_WIDTH-1:0]  push_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0]  pop_value;
      status_type                     status;
   } rsp_type;

   typedef struct packed {
      logic       push;
      logic       mv_rd;
      logic       mv_wr;
      logic       pop_rd;
      logic       res_ld;
      status_type res_status;
      logic       res_data;
      logic       rsp_ld;
   } cmd_type;

   typedef struct packed {
      logic in_empty;
      logic in_full;
      logic out_empty;
      logic rsp_free;
   } sts_type;

endpackage

// ----- rtl/tsq_ram.sv -----
// ----------------------------------------------------------------------------
// tsq_ram
// Simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module tsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/tsq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tsq_ctrl
// Sequencer: accepts a request, runs the stack transfer and the pop read,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module tsq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tsq_pkg::op_type   operation,
   input  tsq_pkg::sts_type  sts,
   output tsq_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MOVE,
      S_POP_RD,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      pend_in        = pend_ff;
      cmd            = '0;
      cmd.res_status = tsq_pkg::ST_OK;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.res_ld = 1'b1;
               if (operation == tsq_pkg::OP_PUSH) begin
                  cmd.res_status = sts.in_full ? tsq_pkg::ST_FULL : tsq_pkg::ST_OK;
                  cmd.push       = !sts.in_full;
                  state_in       = S_DONE;
               end else if (!sts.out_empty) begin
                  cmd.pop_rd   = 1'b1;
                  cmd.res_data = 1'b1;
                  state_in     = S_DONE;
               end else if (sts.in_empty) begin
                  cmd.res_status = tsq_pkg::ST_EMPTY;
                  state_in       = S_DONE;
               end else begin
                  cmd.res_data = 1'b1;
                  pend_in      = 1'b0;
                  state_in     = S_MOVE;
               end
            end
         end
         S_MOVE: begin
            cmd.mv_wr = pend_ff;
            if (!sts.in_empty) begin
               cmd.mv_rd = 1'b1;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_POP_RD;
               end
            end
         end
         S_POP_RD: begin
            cmd.pop_rd = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_ld = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ----- rtl/tsq_dp.sv -----
// ----------------------------------------------------------------------------
// tsq_dp
// Datapath: the two stack memories, their counts and the output register.
// ----------------------------------------------------------------------------
module tsq_dp #(
   parameter int STACK_DEPTH = tsq_pkg::STACK_DEPTH_DEFAULT,
   parameter int DATA_WIDTH  = tsq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  tsq_pkg::req_type  req_payload,
   input  tsq_pkg::cmd_type  cmd,
   output tsq_pkg::sts_type  sts,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tsq_pkg::rsp_type  rsp_payload
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int VW = tsq_pkg::VALUE_WIDTH;
   localparam int EW = (DATA_WIDTH > VW) ? DATA_WIDTH : VW;

   logic [CW-1:0]         in_count_ff, in_count_in;
   logic [CW-1:0]         out_count_ff, out_count_in;
   logic [CW-1:0]         in_dec, out_dec;
   logic [DATA_WIDTH-1:0] ib_rdata, ob_rdata, push_word;
   logic [EW-1:0]         ob_ext;

   tsq_pkg::status_type   res_status_ff;
   logic                  res_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   tsq_pkg::rsp_type      rsp_ff;

   assign in_dec    = in_count_ff - CW'(1);
   assign out_dec   = out_count_ff - CW'(1);
   assign push_word = DATA_WIDTH'($unsigned(req_payload.push_value));
   assign ob_ext    = EW'($signed(ob_rdata));

   tsq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_inbound (
      .clock (clock),
      .we    (cmd.push),
      .waddr (in_count_ff[AW-1:0]),
      .wdata (push_word),
      .re    (cmd.mv_rd),
      .raddr (in_dec[AW-1:0]),
      .rdata (ib_rdata)
   );

   tsq_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (STACK_DEPTH)
   ) u_outbound (
      .clock (clock),
      .we    (cmd.mv_wr),
      .waddr (out_count_ff[AW-1:0]),
      .wdata (ib_rdata),
      .re    (cmd.pop_rd),
      .raddr (out_dec[AW-1:0]),
      .rdata (ob_rdata)
   );

   always_comb begin
      in_count_in  = in_count_ff;
      out_count_in = out_count_ff;
      if (cmd.push) begin
         in_count_in = in_count_ff + CW'(1);
      end else if (cmd.mv_rd) begin
         in_count_in = in_dec;
      end
      if (cmd.mv_wr) begin
         out_count_in = out_count_ff + CW'(1);
      end else if (cmd.pop_rd) begin
         out_count_in = out_dec;
      end
   end

   assign sts.in_empty  = (in_count_ff == '0);
   assign sts.in_full   = (in_count_ff == CW'(STACK_DEPTH));
   assign sts.out_empty = (out_count_ff == '0);
   assign sts.rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_ld) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_count_ff  <= '0;
         out_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_count_ff  <= in_count_in;
         out_count_ff <= out_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_ld) begin
         res_status_ff <= cmd.res_status;
         res_data_ff   <= cmd.res_data;
      end
      if (cmd.rsp_ld) begin
         rsp_ff.status    <= res_status_ff;
         rsp_ff.pop_value <= res_data_ff ? $signed(ob_ext[VW-1:0]) : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_in_bound: assert property (@(posedge clock) disable iff (reset)
      in_count_ff <= CW'(STACK_DEPTH))
      else $error("inbound count beyond depth");

   a_out_bound: assert property (@(posedge clock) disable iff (reset)
      out_count_ff <= CW'(STACK_DEPTH))
      else $error("outbound count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> !sts.in_full)
      else $error("push into full inbound stack");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_rd |-> !sts.out_empty && !cmd.mv_wr)
      else $error("pop read from empty outbound stack");

   a_move_src: assert property (@(posedge clock) disable iff (reset)
      cmd.mv_rd |-> !sts.in_empty && sts.out_empty == (out_count_ff == '0) && !cmd.push)
      else $error("transfer read from empty inbound stack");

endmodule

// ----- rtl/two_stack_queue.sv -----
// ----------------------------------------------------------------------------
// two_stack_queue
// FIFO queue built from an inbound and an outbound stack in two RAMs.
//
//   channel   ports                         direction   payload
//   request   req_valid req_stall req_payload  in          operation, push_value
//   response  rsp_valid rsp_stall rsp_payload  out         pop_value, status
//
// A push, or a pop from a non-empty outbound stack, goes straight to the final step.
// A pop that finds the outbound stack empty first moves all n inbound words,
// one per cycle over the inbound RAM read port, then reads the outbound stack.
// Reset is synchronous and empties both stacks at once; the RAMs need no clear.
// The next request is taken as soon as its result sits in the output register;
// a stalled response holds the block in its final step until taken.
// ----------------------------------------------------------------------------
module two_stack_queue #(
   parameter int STACK_DEPTH = tsq_pkg::STACK_DEPTH_DEFAULT,
   parameter int DATA_WIDTH  = tsq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tsq_pkg::req_type  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tsq_pkg::rsp_type  rsp_payload
);

   tsq_pkg::cmd_type cmd;
   tsq_pkg::sts_type sts;

   tsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .operation (req_payload.operation),
      .sts       (sts),
      .cmd       (cmd)
   );

   tsq_dp #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- tb/two_stack_queue_test.sv -----
// ----------------------------------------------------------------------------
// two_stack_queue_test
// Checks the two-stack FIFO against a behavioral queue model. A directed
// opening covers data extremes, pops on an empty queue and the order reversal
// of a transfer. Random bursts then fill the inbound stack past full, drain
// the queue past empty and mix pushes with pops. Each response is compared in
// order with the predicted pop value and status. Both channels idle at random
// for the first two thirds of the run.
// ----------------------------------------------------------------------------
class queue_ledger;
   localparam int DEPTH = tsq_pkg::STACK_DEPTH_DEFAULT;

   logic [tsq_pkg::VALUE_WIDTH-1:0] inbound_words [DEPTH];
   logic [tsq_pkg::VALUE_WIDTH-1:0] outbound_words [DEPTH];
   int                              inbound_fill;
   int                              outbound_fill;
   tsq_pkg::rsp_type                pending_replies [$];
   int                              mismatches;

   function new();
      inbound_fill  = 0;
      outbound_fill = 0;
      mismatches    = 0;
   endfunction

   function void note_request(tsq_pkg::req_type r);
      tsq_pkg::rsp_type want;
      want.pop_value = '0;
      want.status    = tsq_pkg::ST_OK;
      if (r.operation == tsq_pkg::OP_PUSH) begin
         if (inbound_fill >= DEPTH) begin
            want.status = tsq_pkg::ST_FULL;
         end else begin
            inbound_words[inbound_fill] = r.push_value;
            inbound_fill++;
         end
      end else begin
         // refill outbound in reverse so the oldest word lands on top
         if (outbound_fill == 0) begin
            while (inbound_fill > 0) begin
               inbound_fill--;
               outbound_words[outbound_fill] = inbound_words[inbound_fill];
               outbound_fill++;
            end
         end
         if (outbound_fill == 0) begin
            want.status = tsq_pkg::ST_EMPTY;
         end else begin
            outbound_fill--;
            want.pop_value = outbound_words[outbound_fill];
         end
      end
      pending_replies.push_back(want);
   endfunction

   function void check_response(tsq_pkg::rsp_type got);
      tsq_pkg::rsp_type want;
      if (pending_replies.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: response with no request pending: pop_value %0d status %0d",
                     $time, got.pop_value, got.status);
         return;
      end
      want = pending_replies.pop_front();
      if (got.pop_value !== want.pop_value || got.status !== want.status) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: mismatch: pop_value exp %0d got %0d, status exp %0d got %0d",
                     $time, want.pop_value, got.pop_value, want.status, got.status);
      end
   endfunction
endclass

module two_stack_queue_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = tsq_pkg::STACK_DEPTH_DEFAULT;
   localparam int RUN_ITEMS    = 1900;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   tsq_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   tsq_pkg::rsp_type rsp_payload;

   int          send_idle_pct;
   int          recv_idle_pct;
   int          items_sent;
   int          cycle_count;
   queue_ledger ledger = new();

   two_stack_queue dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [tsq_pkg::VALUE_WIDTH-1:0] pick_word();
      case ($urandom_range(15))
         0: return '0;
         1: return '1;
         2: return 32'h7fff_ffff;
         3: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input tsq_pkg::op_type op,
                               input logic [tsq_pkg::VALUE_WIDTH-1:0] value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{operation: op, push_value: value};
      do @(posedge clock); while (req_stall);
      ledger.note_request(req_payload);
      items_sent++;
      if (items_sent == RUN_ITEMS / 3) begin
         send_idle_pct = 48;
         recv_idle_pct = 10;
      end else if (items_sent == 2 * RUN_ITEMS / 3) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         ledger.check_response(rsp_payload);

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_payload   = '0;
      rsp_stall     = 1'b0;
      send_idle_pct = 10;
      recv_idle_pct = 48;
      items_sent    = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(tsq_pkg::OP_POP, $urandom);
      send_request(tsq_pkg::OP_PUSH, 32'h0000_0000);
      send_request(tsq_pkg::OP_PUSH, 32'hffff_ffff);
      send_request(tsq_pkg::OP_PUSH, 32'h7fff_ffff);
      send_request(tsq_pkg::OP_PUSH, 32'h8000_0000);
      send_request(tsq_pkg::OP_PUSH, 32'h5555_5555);
      send_request(tsq_pkg::OP_PUSH, 32'haaaa_aaaa);
      send_request(tsq_pkg::OP_POP, 32'hffff_ffff);
      send_request(tsq_pkg::OP_PUSH, 32'h0000_0001);
      send_request(tsq_pkg::OP_PUSH, 32'h0000_0002);
      repeat (5) send_request(tsq_pkg::OP_POP, $urandom);
      repeat (2) send_request(tsq_pkg::OP_POP, $urandom);
      send_request(tsq_pkg::OP_POP, $urandom);

      while (items_sent < RUN_ITEMS) begin
         case ($urandom_range(9))
            0, 1, 2:
               repeat ($urandom_range(40, 1))
                  send_request(($urandom_range(99) < 85) ? tsq_pkg::OP_PUSH
                                                         : tsq_pkg::OP_POP, pick_word());
            3, 4:
               repeat ($urandom_range(40, 1))
                  send_request(($urandom_range(99) < 15) ? tsq_pkg::OP_PUSH
                                                         : tsq_pkg::OP_POP, pick_word());
            5, 6, 7:
               repeat ($urandom_range(40, 1))
                  send_request($urandom_range(1) ? tsq_pkg::OP_PUSH : tsq_pkg::OP_POP,
                               pick_word());
            8: begin
               // fill inbound, then push into a full stack
               while (ledger.inbound_fill < DEPTH)
                  send_request(tsq_pkg::OP_PUSH, pick_word());
               repeat ($urandom_range(3, 1)) send_request(tsq_pkg::OP_PUSH, pick_word());
            end
            default: begin
               // drain, then pop an empty queue
               while (ledger.inbound_fill + ledger.outbound_fill > 0)
                  send_request(tsq_pkg::OP_POP, $urandom);
               repeat ($urandom_range(2, 1)) send_request(tsq_pkg::OP_POP, $urandom);
            end
         endcase
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (ledger.mismatches == 0 && ledger.pending_replies.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
